// ----- rtl/occupancy_cell_odds_fusion_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the occupancy cell odds fusion core
// Each use names the label, the antecedent and the consequent.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_CELL_ODDS_FUSION_CORE_ASSERT_SVH
`define OCCUPANCY_CELL_ODDS_FUSION_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define OCOF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ocof assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define OCOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ocof assertion failed");

`endif

// ----- rtl/ocof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocof_pkg
// Widths, constants and the divider stage record shared by the fusion core.
// ----------------------------------------------------------------------------
package ocof_pkg;

  localparam int NUM_FIELDS      = 3;
  localparam int NUM_SOURCES_DEF = 3;

  localparam int CW  = 8;   // cell field width
  localparam int PW  = 7;   // kept percent or complement, 0..100
  localparam int PPW = 14;  // product of two factors
  localparam int NW  = 20;  // product of three factors, at most 100^3
  localparam int TW  = NW + 1;  // N + D
  localparam int QW  = 7;   // quotient, 0..100
  localparam int RW  = TW + QW; // dividend and shifted divisor width

  localparam logic [CW-1:0] PCT_LIMIT    = CW'(100);
  localparam logic [PW-1:0] PCT_FULL     = PW'(100);
  localparam logic [PW-1:0] FACTOR_ONE   = PW'(1);
  localparam logic [RW-1:0] SCALE_X2     = RW'(200);
  localparam logic [CW-1:0] UNKNOWN_CODE = 8'hFF;

  typedef struct packed {
    logic          unk;
    logic [RW-1:0] rem;
    logic [TW-1:0] tot;
    logic [QW-1:0] quo;
  } ocof_div_t;

endpackage

// ----- rtl/ocof_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocof_front
// Source decode, odds products and dividend set-up in three register stages.
// ----------------------------------------------------------------------------
module ocof_front #(
  parameter int NUM_SOURCES = ocof_pkg::NUM_SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [ocof_pkg::CW-1:0]    cell_a,
  input  logic [ocof_pkg::CW-1:0]    cell_b,
  input  logic [ocof_pkg::CW-1:0]    cell_c,
  output logic                       out_vld_r,
  output ocof_pkg::ocof_div_t        out_dat_r
);

  logic [ocof_pkg::CW-1:0]  raw [ocof_pkg::NUM_FIELDS];
  logic [ocof_pkg::PW-1:0]  pf  [ocof_pkg::NUM_FIELDS];
  logic [ocof_pkg::PW-1:0]  df  [ocof_pkg::NUM_FIELDS];

  logic                     va_r, vb_r;
  logic [ocof_pkg::PPW-1:0] pab_r, dab_r;
  logic [ocof_pkg::PW-1:0]  pc_r, dc_r;
  logic [ocof_pkg::NW-1:0]  n_r, d_r;

  logic [ocof_pkg::TW-1:0]  tot;
  ocof_pkg::ocof_div_t      dat_nxt;

  assign raw[0] = cell_a;
  assign raw[1] = cell_b;
  assign raw[2] = cell_c;

  // keep a source only in 0..99 and within the configured count
  always_comb begin
    for (int k = 0; k < ocof_pkg::NUM_FIELDS; k++) begin
      if ((k < NUM_SOURCES) && (raw[k] < ocof_pkg::PCT_LIMIT)) begin
        pf[k] = raw[k][ocof_pkg::PW-1:0];
        df[k] = ocof_pkg::PCT_FULL - raw[k][ocof_pkg::PW-1:0];
      end else begin
        pf[k] = ocof_pkg::FACTOR_ONE;
        df[k] = ocof_pkg::FACTOR_ONE;
      end
    end
  end

  assign tot = ocof_pkg::TW'(n_r) + ocof_pkg::TW'(d_r);

  always_comb begin
    dat_nxt.unk = (n_r == d_r);
    dat_nxt.rem = ocof_pkg::RW'(n_r) * ocof_pkg::SCALE_X2 + ocof_pkg::RW'(tot);
    dat_nxt.tot = tot;
    dat_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      va_r      <= in_vld;
      vb_r      <= va_r;
      out_vld_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pab_r     <= ocof_pkg::PPW'(pf[0]) * ocof_pkg::PPW'(pf[1]);
      dab_r     <= ocof_pkg::PPW'(df[0]) * ocof_pkg::PPW'(df[1]);
      pc_r      <= pf[2];
      dc_r      <= df[2];
      n_r       <= ocof_pkg::NW'(pab_r) * ocof_pkg::NW'(pc_r);
      d_r       <= ocof_pkg::NW'(dab_r) * ocof_pkg::NW'(dc_r);
      out_dat_r <= dat_nxt;
    end
  end

endmodule

// ----- rtl/ocof_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocof_div_step
// One restoring division step: trial subtract of the shifted divisor.
// ----------------------------------------------------------------------------
module ocof_div_step #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  ocof_pkg::ocof_div_t in_dat,
  output logic                out_vld_r,
  output ocof_pkg::ocof_div_t out_dat_r
);

  logic [ocof_pkg::RW-1:0] dvs;
  logic                    ge;
  ocof_pkg::ocof_div_t     dat_nxt;

  // divisor is 2*(N+D), weighted by this step's quotient bit
  assign dvs = {{(ocof_pkg::RW - ocof_pkg::TW - 1){1'b0}}, in_dat.tot, 1'b0} << SHIFT;
  assign ge  = (in_dat.rem >= dvs);

  always_comb begin
    dat_nxt     = in_dat;
    dat_nxt.rem = ge ? (in_dat.rem - dvs) : in_dat.rem;
    dat_nxt.quo = {in_dat.quo[ocof_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dat_r <= dat_nxt;
    end
  end

endmodule

// ----- rtl/occupancy_cell_odds_fusion_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_cell_odds_fusion_core
// Bayesian odds fusion of one grid cell from up to three source occupancies.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | beat payload
//   ---------+-----------+-----------------------+------------------------------
//   in_      | input     | in_valid / in_stall   | in_cell_a, in_cell_b, in_cell_c
//   out_     | output    | out_valid / out_stall | out_fused_cell
//
// Pipeline: one beat accepted per clock while the output is not held; each
//   beat passes through 3 front stages (decode and first product, second
//   product, dividend set-up), then 7 divider stages, one quotient bit each.
// Reset: synchronous, active low; clears every stage valid bit, payload is
//   left as it is.
// Stalls: the whole pipe holds while the output beat waits; in_stall is high
//   exactly then, so nothing is dropped or repeated.
//
// Kept sources (0..99) give N = prod p and D = prod (100 - p). Equal N and D,
// including no kept source, give unknown (-1). Otherwise the result is
// floor((200*N + N + D) / (2*(N + D))), i.e. 100*N/(N+D) rounded half up.
// ----------------------------------------------------------------------------
`include "occupancy_cell_odds_fusion_core_assert.svh"

module occupancy_cell_odds_fusion_core #(
  parameter int NUM_SOURCES = ocof_pkg::NUM_SOURCES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ocof_pkg::CW-1:0] in_cell_a,
  input  logic signed [ocof_pkg::CW-1:0] in_cell_b,
  input  logic signed [ocof_pkg::CW-1:0] in_cell_c,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ocof_pkg::CW-1:0] out_fused_cell
);

  localparam int QW = ocof_pkg::QW;

  // pipe advances unless the finished beat is held at the output
  logic                en;
  logic                vld [QW+1];
  ocof_pkg::ocof_div_t dat [QW+1];
  logic [QW:0]         vld_vec;

  assign en       = !(vld[QW] && out_stall);
  assign in_stall = !en;

  ocof_front #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .cell_a    (in_cell_a),
    .cell_b    (in_cell_b),
    .cell_c    (in_cell_c),
    .out_vld_r (vld[0]),
    .out_dat_r (dat[0])
  );

  // quotient bits from most significant down, one register stage each
  for (genvar i = 0; i < QW; i++) begin : g_div
    ocof_div_step #(
      .SHIFT (QW - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_vld    (vld[i]),
      .in_dat    (dat[i]),
      .out_vld_r (vld[i+1]),
      .out_dat_r (dat[i+1])
    );
  end

  for (genvar j = 0; j <= QW; j++) begin : g_vvec
    assign vld_vec[j] = vld[j];
  end

  // the last divider stage is the output register
  assign out_valid      = vld[QW];
  assign out_fused_cell = dat[QW].unk ? $signed(ocof_pkg::UNKNOWN_CODE)
                                      : $signed({1'b0, dat[QW].quo});

  // fused value is unknown or a percentage, never anything else
  `OCOF_ASSERT_NOW(a_fused_range, out_valid, out_fused_cell >= -1 && out_fused_cell <= 100)
  // a held output freezes every stage valid bit
  `OCOF_ASSERT_NEXT(a_pipe_frozen, out_valid && out_stall, $stable(vld_vec))
  // an accepted beat lands in the first stage
  `OCOF_ASSERT_NEXT(a_beat_enters, in_valid && !in_stall, u_front.va_r)

endmodule
